// ===== rtl/fct_pkg.sv =====
package fct_pkg;

  localparam int COORD_W      = 32;
  localparam int NORM_W       = 16;
  localparam int IDX_W        = 3;
  localparam int PROD_W       = NORM_W + COORD_W;
  localparam int ACC_W        = 50;
  localparam int OFFSET_SHIFT = 15;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_POINT  = 2'd1,
    REQ_SPHERE = 2'd2,
    REQ_BOX    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_ADD_Z,
    ST_CHECK
  } state_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef struct packed {
    logic signed [NORM_W-1:0]  nx;
    logic signed [NORM_W-1:0]  ny;
    logic signed [NORM_W-1:0]  nz;
    logic signed [COORD_W-1:0] d;
  } plane_t;

  typedef struct packed {
    logic  init;
    logic  accum;
    axis_t axis;
  } mac_ctrl_t;

endpackage

// ===== rtl/fct_plane_regs.sv =====
module fct_plane_regs #(
  parameter int NUM_PLANES = 6,
  parameter int PI_W       = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [fct_pkg::IDX_W-1:0]        wr_idx,
  input  logic signed [fct_pkg::COORD_W-1:0] wr_ax,
  input  logic signed [fct_pkg::COORD_W-1:0] wr_ay,
  input  logic signed [fct_pkg::COORD_W-1:0] wr_az,
  input  logic signed [fct_pkg::COORD_W-1:0] wr_d,
  input  logic [PI_W-1:0]                  rd_idx,
  output fct_pkg::plane_t                  rd_plane
);
  import fct_pkg::*;

  plane_t planes [NUM_PLANES];
  logic   wr_hit;

  // drop writes beyond the last plane
  assign wr_hit = wr_en && ({1'b0, wr_idx} < (IDX_W + 1)'(NUM_PLANES));

  // hold planes, replace one on a write beat
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        planes[i] <= '0;
      end
    end else if (wr_hit) begin
      planes[wr_idx[PI_W-1:0]] <= '{nx: wr_ax[NORM_W-1:0], ny: wr_ay[NORM_W-1:0],
                                    nz: wr_az[NORM_W-1:0], d: wr_d};
    end
  end

  assign rd_plane = planes[rd_idx];

endmodule

// ===== rtl/fct_mac.sv =====
module fct_mac (
  input  logic                               clk,
  input  fct_pkg::mac_ctrl_t                 ctrl,
  input  fct_pkg::plane_t                    plane,
  input  logic signed [fct_pkg::COORD_W-1:0] pa_x,
  input  logic signed [fct_pkg::COORD_W-1:0] pa_y,
  input  logic signed [fct_pkg::COORD_W-1:0] pa_z,
  input  logic signed [fct_pkg::COORD_W-1:0] pb_x,
  input  logic signed [fct_pkg::COORD_W-1:0] pb_y,
  input  logic signed [fct_pkg::COORD_W-1:0] pb_z,
  input  logic [2:0]                         b_gt_a,
  input  logic                               is_box,
  input  logic signed [fct_pkg::ACC_W-1:0]   thr,
  output logic                               reject
);
  import fct_pkg::*;

  logic signed [NORM_W-1:0]  mul_n;
  logic signed [COORD_W-1:0] mul_a;
  logic signed [COORD_W-1:0] mul_b;
  logic                      mul_gt;
  logic                      sel_b;
  logic signed [COORD_W-1:0] mul_c;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  // pick normal component and coordinate for this axis
  always_comb begin
    case (ctrl.axis)
      AX_X: begin
        mul_n  = plane.nx;
        mul_a  = pa_x;
        mul_b  = pb_x;
        mul_gt = b_gt_a[0];
      end
      AX_Y: begin
        mul_n  = plane.ny;
        mul_a  = pa_y;
        mul_b  = pb_y;
        mul_gt = b_gt_a[1];
      end
      AX_Z: begin
        mul_n  = plane.nz;
        mul_a  = pa_z;
        mul_b  = pb_z;
        mul_gt = b_gt_a[2];
      end
      default: begin
        mul_n  = '0;
        mul_a  = pa_x;
        mul_b  = pb_x;
        mul_gt = 1'b0;
      end
    endcase
    // for a box take the corner farthest along the normal
    sel_b     = is_box && (mul_n[NORM_W-1] ? !mul_gt : mul_gt);
    mul_c     = sel_b ? mul_b : mul_a;
    prod_next = mul_n * mul_c;
  end

  // register product, then accumulate on the following cycle
  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (ctrl.init) begin
      acc <= {{(ACC_W - COORD_W - OFFSET_SHIFT){plane.d[COORD_W-1]}}, plane.d,
              {OFFSET_SHIFT{1'b0}}};
    end else if (ctrl.accum) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  assign reject = (acc <= thr);

endmodule

// ===== rtl/frustum_cull_tester.sv =====
// Each plane visited takes the MUL_X, MUL_Y, MUL_Z, ADD_Z and CHECK states; a kept object
// visits all NUM_PLANES planes, a rejected one stops at the rejecting plane.
// Tests do not overlap: in_ready is high only in ST_IDLE, and the single shared 16x32
// multiplier does three products per plane; a plane write is taken in ST_IDLE and stays there.
// Reset (rst, synchronous) clears all planes to zero and empties the result.
module frustum_cull_tester #(
  parameter int NUM_PLANES = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         req_type,
  input  logic [fct_pkg::IDX_W-1:0]          plane_index,
  input  logic signed [fct_pkg::COORD_W-1:0] a_x,
  input  logic signed [fct_pkg::COORD_W-1:0] a_y,
  input  logic signed [fct_pkg::COORD_W-1:0] a_z,
  input  logic signed [fct_pkg::COORD_W-1:0] b_x,
  input  logic signed [fct_pkg::COORD_W-1:0] b_y,
  input  logic signed [fct_pkg::COORD_W-1:0] b_z,
  input  logic signed [fct_pkg::COORD_W-1:0] scalar,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               in_view
);
  import fct_pkg::*;

  localparam int PI_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  state_t                    state, state_next;
  logic [PI_W-1:0]           plane_cnt, plane_cnt_next;
  logic                      out_valid_next;
  logic                      in_view_next;
  logic                      accept;
  logic                      load;
  req_t                      req;
  mac_ctrl_t                 ctrl;
  plane_t                    plane;
  logic                      reject;
  logic                      last_plane;
  logic                      out_free;

  logic signed [COORD_W-1:0] pa_x, pa_y, pa_z, pb_x, pb_y, pb_z;
  logic [2:0]                b_gt_a;
  logic                      is_box;
  logic signed [ACC_W-1:0]   thr;
  logic signed [ACC_W-1:0]   thr_next;
  logic signed [ACC_W-1:0]   s_ext;

  assign req      = req_t'(req_type);
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = accept && (req != REQ_WRITE);

  fct_plane_regs #(
    .NUM_PLANES (NUM_PLANES),
    .PI_W       (PI_W)
  ) u_planes (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && (req == REQ_WRITE)),
    .wr_idx   (plane_index),
    .wr_ax    (a_x),
    .wr_ay    (a_y),
    .wr_az    (a_z),
    .wr_d     (scalar),
    .rd_idx   (plane_cnt),
    .rd_plane (plane)
  );

  fct_mac u_mac (
    .clk    (clk),
    .ctrl   (ctrl),
    .plane  (plane),
    .pa_x   (pa_x),
    .pa_y   (pa_y),
    .pa_z   (pa_z),
    .pb_x   (pb_x),
    .pb_y   (pb_y),
    .pb_z   (pb_z),
    .b_gt_a (b_gt_a),
    .is_box (is_box),
    .thr    (thr),
    .reject (reject)
  );

  // rejection threshold: point dist <= 0, sphere dist <= -r, box dist < 0
  always_comb begin
    s_ext = {{(ACC_W - COORD_W){scalar[COORD_W-1]}}, scalar};
    case (req)
      REQ_SPHERE: thr_next = -(s_ext <<< OFFSET_SHIFT);
      REQ_BOX:    thr_next = '1;
      default:    thr_next = '0;
    endcase
  end

  // capture the object on a test beat
  always_ff @(posedge clk) begin
    if (load) begin
      pa_x   <= a_x;
      pa_y   <= a_y;
      pa_z   <= a_z;
      pb_x   <= b_x;
      pb_y   <= b_y;
      pb_z   <= b_z;
      b_gt_a <= {b_z > a_z, b_y > a_y, b_x > a_x};
      is_box <= (req == REQ_BOX);
      thr    <= thr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      plane_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      plane_cnt <= plane_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    in_view <= in_view_next;
  end

  assign last_plane = (plane_cnt == PI_W'(NUM_PLANES - 1));
  assign out_free   = !out_valid || out_ready;

  // sequence three products and a final add per plane, then check
  always_comb begin
    state_next     = state;
    plane_cnt_next = plane_cnt;
    out_valid_next = out_valid && !out_ready;
    in_view_next   = in_view;
    ctrl           = '{init: 1'b0, accum: 1'b0, axis: AX_X};
    case (state)
      ST_IDLE: begin
        if (load) begin
          plane_cnt_next = '0;
          state_next     = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        ctrl       = '{init: 1'b1, accum: 1'b0, axis: AX_X};
        state_next = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        ctrl       = '{init: 1'b0, accum: 1'b1, axis: AX_Y};
        state_next = ST_MUL_Z;
      end
      ST_MUL_Z: begin
        ctrl       = '{init: 1'b0, accum: 1'b1, axis: AX_Z};
        state_next = ST_ADD_Z;
      end
      ST_ADD_Z: begin
        ctrl       = '{init: 1'b0, accum: 1'b1, axis: AX_X};
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (reject || last_plane) begin
          // hold until the result register is free
          if (out_free) begin
            out_valid_next = 1'b1;
            in_view_next   = !reject;
            state_next     = ST_IDLE;
          end
        end else begin
          plane_cnt_next = plane_cnt + 1'b1;
          state_next     = ST_MUL_X;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/fct_checker.sv =====
module fct_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] req_type,
  input logic       out_valid,
  input logic       out_ready,
  input logic       in_view
);
  import fct_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(in_view))
    else $error("result beat changed while stalled");

  // a test beat keeps the input closed after it is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type != REQ_WRITE) |=> !in_ready ##1 !in_ready)
    else $error("input reopened too early after a test");

  // a plane write leaves the input open and makes no result
  a_write: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type == REQ_WRITE) |=> in_ready && !$rose(out_valid))
    else $error("plane write disturbed the sequencer");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind frustum_cull_tester fct_checker u_fct_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .req_type  (req_type),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .in_view   (in_view)
);

// ===== test/tb_frustum_cull_tester.sv =====
`timescale 1ns / 100ps

module tb_frustum_cull_tester;
  import fct_pkg::*;

  localparam int NUM_PLANES    = 6;
  localparam int RANDOM_BEATS  = 1200;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 100;
  localparam int CYCLE_LIMIT   = 600000;
  localparam logic signed [31:0] Q_TEN  = 32'sd655360;   // 10.0 in Q16.16
  localparam logic signed [31:0] Q_ONE  = 32'sd65536;
  localparam logic signed [31:0] S_MAX  = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S_MIN  = 32'sh80000000;
  localparam logic signed [15:0] N_POS  = 16'sh7FFF;
  localparam logic signed [15:0] N_NEG  = 16'sh8000;

  typedef struct {
    req_t               kind;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] ax, ay, az;
    logic signed [31:0] bx, by, bz;
    logic signed [31:0] s;
  } cull_req_t;

  typedef struct {
    bit in_view;
    int seq;
  } view_expect_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type = '0;
  logic [IDX_W-1:0] plane_index = '0;
  logic signed [31:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [31:0] b_x = '0, b_y = '0, b_z = '0;
  logic signed [31:0] scalar = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic in_view;

  // predictor state: copy of the plane store
  plane_t frustum [NUM_PLANES];
  view_expect_t view_expect_q[$];
  int mismatch_count = 0;
  int beat_seq = 0;
  int useful_beats = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold_req = 1'b0;
  int cycle_count = 0;

  frustum_cull_tester #(.NUM_PLANES(NUM_PLANES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .plane_index(plane_index),
    .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .scalar(scalar),
    .out_valid(out_valid), .out_ready(out_ready),
    .in_view(in_view)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // signed distance scaled by 2^-31, full width
  function automatic longint plane_reach(plane_t p, longint px, longint py, longint pz);
    return longint'($signed(p.nx)) * px + longint'($signed(p.ny)) * py
         + longint'($signed(p.nz)) * pz + (longint'($signed(p.d)) <<< OFFSET_SHIFT);
  endfunction

  function automatic void store_plane(cull_req_t r);
    if (r.idx < NUM_PLANES) begin
      frustum[r.idx].nx = r.ax[15:0];
      frustum[r.idx].ny = r.ay[15:0];
      frustum[r.idx].nz = r.az[15:0];
      frustum[r.idx].d  = r.s;
    end
  endfunction

  function automatic bit cull_predict(cull_req_t r);
    longint ax, ay, az, bx, by, bz, rad, px, py, pz;
    bit keep;
    int below;
    ax = r.ax; ay = r.ay; az = r.az;
    bx = r.bx; by = r.by; bz = r.bz;
    rad = r.s;
    keep = 1'b1;
    for (int k = 0; k < NUM_PLANES && keep; k++) begin
      case (r.kind)
        REQ_POINT: begin
          if (plane_reach(frustum[k], ax, ay, az) <= 0) keep = 1'b0;
        end
        REQ_SPHERE: begin
          if (plane_reach(frustum[k], ax, ay, az) <= -(rad <<< OFFSET_SHIFT)) keep = 1'b0;
        end
        default: begin
          // corners come straight from min/max, no reordering
          below = 0;
          for (int c = 0; c < 8; c++) begin
            px = (c & 1) ? bx : ax;
            py = (c & 2) ? by : ay;
            pz = (c & 4) ? bz : az;
            if (plane_reach(frustum[k], px, py, pz) < 0) below++;
          end
          if (below == 8) keep = 1'b0;
        end
      endcase
    end
    return keep;
  endfunction

  function automatic cull_req_t make_write(int idx, logic signed [15:0] nx,
                                           logic signed [15:0] ny, logic signed [15:0] nz,
                                           logic signed [31:0] d);
    cull_req_t r;
    r.kind = REQ_WRITE;
    r.idx  = idx[IDX_W-1:0];
    // upper halves carry junk that the block must drop
    r.ax = {16'($urandom), nx};
    r.ay = {16'($urandom), ny};
    r.az = {16'($urandom), nz};
    r.bx = $urandom; r.by = $urandom; r.bz = $urandom;
    r.s  = d;
    return r;
  endfunction

  function automatic cull_req_t make_obj(req_t kind, logic signed [31:0] ax,
                                         logic signed [31:0] ay, logic signed [31:0] az,
                                         logic signed [31:0] bx, logic signed [31:0] by,
                                         logic signed [31:0] bz, logic signed [31:0] s);
    cull_req_t r;
    r.kind = kind;
    r.idx  = 3'($urandom);
    r.ax = ax; r.ay = ay; r.az = az;
    r.bx = bx; r.by = by; r.bz = bz;
    r.s  = s;
    return r;
  endfunction

  // offer one beat, hold it until taken, then update the predictor
  task automatic send_req(input cull_req_t r);
    bit taken;
    view_expect_t pending;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= r.kind;
    plane_index <= r.idx;
    a_x <= r.ax; a_y <= r.ay; a_z <= r.az;
    b_x <= r.bx; b_y <= r.by; b_z <= r.bz;
    scalar <= r.s;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    beat_seq++;
    if (r.kind == REQ_WRITE) begin
      store_plane(r);
      if (r.idx < NUM_PLANES) useful_beats++;
    end else begin
      pending.in_view = cull_predict(r);
      pending.seq     = beat_seq;
      view_expect_q.insert(view_expect_q.size(), pending);
      useful_beats++;
    end
  endtask

  task automatic drain_results();
    while (view_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(negedge clk) begin
    view_expect_t head;
    if (!rst && out_valid && out_ready) begin
      if (view_expect_q.size() == 0) begin
        report_mismatch($sformatf("result in_view=%0b with nothing pending", in_view));
      end else begin
        head = view_expect_q.pop_front();
        if (in_view !== head.in_view)
          report_mismatch($sformatf("beat %0d: in_view=%0b, predicted %0b",
                                    head.seq, in_view, head.in_view));
      end
    end
  end

  // all planes zero: every distance is zero
  task automatic test_reset_planes();
    send_req(make_obj(REQ_POINT, 0, 0, 0, $urandom, $urandom, $urandom, $urandom));
    send_req(make_obj(REQ_POINT, S_MAX, S_MIN, S_MAX, 0, 0, 0, 0));
    send_req(make_obj(REQ_SPHERE, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0));
    send_req(make_obj(REQ_SPHERE, 0, 0, 0, 0, 0, 0, S_MAX));
    send_req(make_obj(REQ_SPHERE, 0, 0, 0, 0, 0, 0, -32'sd1));
    send_req(make_obj(REQ_BOX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, 0));
  endtask

  // axis-aligned box frustum, then writes that must be dropped, then a point test
  task automatic test_plane_writes();
    send_req(make_write(0, N_POS, 0, 0, Q_TEN));
    send_req(make_write(1, N_NEG, 0, 0, Q_TEN));
    send_req(make_write(2, 0, N_POS, 0, Q_TEN));
    send_req(make_write(3, 0, N_NEG, 0, Q_TEN));
    send_req(make_write(4, 0, 0, N_POS, S_MAX));
    send_req(make_write(5, 0, 0, N_NEG, Q_TEN));
    send_req(make_write(6, 0, 0, 0, S_MIN));
    send_req(make_write(7, N_NEG, N_NEG, N_NEG, S_MIN));
    send_req(make_obj(REQ_POINT, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_object_extremes();
    // point on a plane is rejected
    send_req(make_obj(REQ_POINT, Q_TEN, 0, 0, 0, 0, 0, 0));
    send_req(make_obj(REQ_POINT, S_MIN, S_MIN, S_MIN, 0, 0, 0, 0));
    // tangent sphere rejected, slightly larger one kept
    send_req(make_obj(REQ_SPHERE, Q_TEN + Q_ONE, 0, 0, 0, 0, 0, Q_ONE));
    send_req(make_obj(REQ_SPHERE, Q_TEN + Q_ONE, 0, 0, 0, 0, 0, 2 * Q_ONE));
    // negative radius shrinks the region
    send_req(make_obj(REQ_SPHERE, 0, 0, 0, 0, 0, 0, -Q_ONE));
    send_req(make_obj(REQ_SPHERE, 0, 0, 0, 0, 0, 0, S_MIN));
    send_req(make_obj(REQ_BOX, -2 * Q_TEN, -2 * Q_TEN, -2 * Q_TEN,
                      2 * Q_TEN, 2 * Q_TEN, 2 * Q_TEN, $urandom));
    // inverted box
    send_req(make_obj(REQ_BOX, 2 * Q_TEN, 2 * Q_TEN, 2 * Q_TEN,
                      -2 * Q_TEN, -2 * Q_TEN, -2 * Q_TEN, 0));
    send_req(make_obj(REQ_BOX, Q_TEN + Q_ONE, 0, 0, Q_TEN + 2 * Q_ONE, Q_ONE, Q_ONE, 0));
    send_req(make_obj(REQ_BOX, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, 0));
  endtask

  function automatic logic signed [31:0] pick_coord();
    logic signed [31:0] v;
    case ($urandom_range(0, 19))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: v = S_MAX;
          1: v = S_MIN;
          2: v = 0;
          default: v = -32'sd1;
        endcase
      end
      default: begin
        v = $urandom_range(0, 160 * 65536);
        v = v - 32'sd5242880;
      end
    endcase
    return v;
  endfunction

  function automatic cull_req_t random_object();
    req_t kind;
    logic signed [31:0] ax, ay, az, bx, by, bz, s;
    kind = req_t'($urandom_range(1, 3));
    ax = pick_coord(); ay = pick_coord(); az = pick_coord();
    bx = $urandom; by = $urandom; bz = $urandom;
    s = $urandom;
    if (kind == REQ_SPHERE) begin
      case ($urandom_range(0, 19))
        0: s = $urandom;
        1, 2: s = -$signed(32'($urandom_range(0, 20 * 65536)));
        default: s = $urandom_range(0, 20 * 65536);
      endcase
    end else if (kind == REQ_BOX) begin
      case ($urandom_range(0, 19))
        0: begin
          bx = pick_coord(); by = pick_coord(); bz = pick_coord();
        end
        1, 2: begin
          bx = ax - $urandom_range(0, 40 * 65536);
          by = ay - $urandom_range(0, 40 * 65536);
          bz = az - $urandom_range(0, 40 * 65536);
        end
        default: begin
          bx = ax + $urandom_range(0, 40 * 65536);
          by = ay + $urandom_range(0, 40 * 65536);
          bz = az + $urandom_range(0, 40 * 65536);
        end
      endcase
    end
    return make_obj(kind, ax, ay, az, bx, by, bz, s);
  endfunction

  // six roughly axis-facing planes around the origin
  task automatic load_random_frustum();
    logic signed [15:0] n [3];
    logic signed [15:0] lead;
    logic signed [31:0] d;
    for (int k = 0; k < NUM_PLANES; k++) begin
      for (int a = 0; a < 3; a++) n[a] = $urandom_range(0, 16'h2000) - 16'sh1000;
      lead = $urandom_range(16'h5000, 16'h7FFF);
      n[(k / 2) % 3] = (k % 2) ? -lead : lead;
      case ($urandom_range(0, 7))
        0: d = -$signed(32'($urandom_range(0, 8 * 65536)));
        1: d = $urandom;
        default: d = $urandom_range(65536, 64 * 65536);
      endcase
      send_req(make_write(k, n[0], n[1], n[2], d));
    end
  endtask

  // stall the output so the block backs up into its input
  task automatic test_output_hold();
    tx_idle_pct = 0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 16; i++) send_req(random_object());
    // drop valid so the last beat is not offered again
    in_valid <= 1'b0;
    while (rx_hold_req) @(posedge clk);
    drain_results();
  endtask

  task automatic test_random_culling();
    cull_req_t r;
    int start;
    int next_swap;
    start = useful_beats;
    next_swap = start;
    load_random_frustum();
    while (useful_beats - start < RANDOM_BEATS) begin
      if (useful_beats >= next_swap) begin
        tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
        rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
        next_swap = useful_beats + 150;
      end
      case ($urandom_range(0, 39))
        0: load_random_frustum();
        1, 2: begin
          // noise beat: any type, any index, any payload
          r.kind = req_t'($urandom_range(0, 3));
          r.idx  = 3'($urandom);
          r.ax = $urandom; r.ay = $urandom; r.az = $urandom;
          r.bx = $urandom; r.by = $urandom; r.bz = $urandom;
          r.s  = $urandom;
          send_req(r);
        end
        default: send_req(random_object());
      endcase
    end
  endtask

  initial begin
    foreach (frustum[k]) frustum[k] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_planes();
    test_plane_writes();
    test_object_extremes();
    test_output_hold();
    test_random_culling();
    in_valid <= 1'b0;
    drain_results();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fct_pkg.sv
rtl/fct_plane_regs.sv
rtl/fct_mac.sv
rtl/frustum_cull_tester.sv
rtl/fct_checker.sv
test/tb_frustum_cull_tester.sv
